>>> hdl/palette_rle_sprite_line_decoder_assert.svh
// Assertion macros shared by the sprite line decoder RTL.
`ifndef PALETTE_RLE_SPRITE_LINE_DECODER_ASSERT_SVH
`define PALETTE_RLE_SPRITE_LINE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define PRSLD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prsld: same-cycle check failed");
// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PRSLD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prsld: next-cycle check failed");
`else
`define PRSLD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PRSLD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/prsld_pkg.sv
// Shared types and constants of the palette run-length sprite line decoder.
package prsld_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_WIDTH_DEF       = 4096;

    localparam int FRAME_WIDTH_W = 12;
    localparam int COLUMN_W      = 12;
    localparam int COLOR_W       = 16;
    localparam int ALPHA_W       = 5;
    localparam int PIXEL_W       = ALPHA_W + COLOR_W;
    localparam int RUN_W         = 6;
    localparam int BYTE_W        = 8;
    localparam int INDEX_W       = 8;

    localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 12'd1;
    localparam logic [ALPHA_W-1:0]       ALPHA_OPAQUE      = 5'h1F;

    // Token kinds, taken from the top two bits of a token byte.
    localparam logic [1:0] TK_ALPHA   = 2'b00;
    localparam logic [1:0] TK_LITERAL = 2'b01;
    localparam logic [1:0] TK_REPEAT  = 2'b10;
    localparam logic [1:0] TK_SKIP    = 2'b11;

    typedef enum logic [3:0] {
        PH_TOKEN     = 4'b0001,
        PH_RUN_ALPHA = 4'b0010,
        PH_RUN_INDEX = 4'b0100,
        PH_LITERAL   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_EMIT   = 3'b100
    } ctl_state_t;

    typedef struct packed {
        logic                 action;
        logic                 line_start;
        logic [BYTE_W-1:0]    data_byte;
        logic [INDEX_W-1:0]   palette_index;
        logic [COLOR_W-1:0]   palette_color;
    } item_t;

    typedef struct packed {
        logic                 pixel_valid;
        logic [COLUMN_W-1:0]  column;
        logic [PIXEL_W-1:0]   pixel_value;
        logic                 line_done;
        logic                 overrun;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [INDEX_W-1:0]   index;
        logic [COLOR_W-1:0]   color;
    } pal_req_t;

endpackage

>>> hdl/palette_rle_sprite_line_decoder.sv
// Top level of the palette run-length sprite line decoder.
//
//  Channel  Direction  Handshake          Carries
//  s_*      in         s_valid / s_ready  palette write or one encoded stream byte
//  m_*      out        m_valid / m_ready  one pixel write or a flag-only result
//  cfg_*    in         cfg_we             frame width, written with no wait
//
// A palette write leaves the decoder idle and ready. A stream byte first reads the
// palette RAM at the byte, then is decoded; a repeat or alpha run of visible pixels
// then goes out one pixel a cycle, while m_ready holds, from the single result register.
// Reset is synchronous and active low; the palette reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed and items are taken at once.
// A stalled m_ready holds the decoder before its next result, never the input side
// of a palette write.
`include "palette_rle_sprite_line_decoder_assert.svh"

module palette_rle_sprite_line_decoder import prsld_pkg::*; #(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int MAX_WIDTH       = MAX_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [FRAME_WIDTH_W-1:0]  cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic                      s_line_start,
    input  logic [BYTE_W-1:0]         s_data_byte,
    input  logic [INDEX_W-1:0]        s_palette_index,
    input  logic [COLOR_W-1:0]        s_palette_color,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_pixel_valid,
    output logic [COLUMN_W-1:0]       m_column,
    output logic [PIXEL_W-1:0]        m_pixel_value,
    output logic                      m_line_done,
    output logic                      m_overrun,
    output logic                      m_last
);

    // Column counter width: the line width plus the longest run that can pass it.
    localparam int CW = $clog2(MAX_WIDTH + 2**RUN_W);

    logic [FRAME_WIDTH_W-1:0] frame_width_reg;
    logic [FRAME_WIDTH_W-1:0] frame_width_next;
    logic [CW-1:0]            w_eff;
    item_t                    in_item;
    result_t                  out_res;
    pal_req_t                 pal_req;
    logic [COLOR_W-1:0]       pal_color;

    // The user must change the frame width register only while the decoder is idle; the block does not enforce it.
    assign frame_width_next = cfg_we ? cfg_wdata : frame_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= FRAME_WIDTH_RESET;
        end else begin
            frame_width_reg <= frame_width_next;
        end
    end

    // A width of zero acts as one pixel; a width above the supported maximum is clamped.
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(frame_width_reg);
        end
    end

    assign in_item.action        = s_action;
    assign in_item.line_start    = s_line_start;
    assign in_item.data_byte     = s_data_byte;
    assign in_item.palette_index = s_palette_index;
    assign in_item.palette_color = s_palette_color;

    prsld_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (pal_req),
        .rd_color (pal_color)
    );

    prsld_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (in_item),
        .w_eff     (w_eff),
        .pal_req   (pal_req),
        .pal_color (pal_color),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_pixel_valid = out_res.pixel_valid;
    assign m_column      = out_res.column;
    assign m_pixel_value = out_res.pixel_value;
    assign m_line_done   = out_res.line_done;
    assign m_overrun     = out_res.overrun;
    assign m_last        = out_res.last;

    // A result without a pixel is always the final one of its item.
    `PRSLD_ASSERT_IMPL(a_flag_only_is_last, aclk, aresetn, m_valid && !m_pixel_valid, m_last)
    // Every pixel shown lies inside the current line width.
    `PRSLD_ASSERT_IMPL(a_pixel_in_line, aclk, aresetn, m_valid && m_pixel_valid, 32'(m_column) < 32'(w_eff))
    // A stream byte always holds off the input for its decode cycle.
    `PRSLD_ASSERT_NEXT(a_byte_holds_input, aclk, aresetn, s_valid && s_ready && s_action, !s_ready)
    // A palette write finishes in its own cycle.
    `PRSLD_ASSERT_NEXT(a_pal_write_one_cycle, aclk, aresetn, s_valid && s_ready && !s_action, s_ready)

endmodule

>>> hdl/prsld_ram.sv
// Generic single-port synchronous RAM with a registered read.
module prsld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/prsld_palette.sv
// Palette store: RAM plus per-entry valid bits so unwritten entries read as zero.
module prsld_palette import prsld_pkg::*; #(
    parameter int ENTRIES = PALETTE_ENTRIES_DEF,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pal_req_t           req,
    output logic [COLOR_W-1:0] rd_color
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic               hit_reg;
    logic               hit_next;
    logic [AW-1:0]      addr;
    logic [COLOR_W-1:0] ram_q;

    assign addr = AW'(req.index);

    always_comb begin
        valid_next = valid_reg;
        if (req.wr_en) begin
            valid_next[addr] = 1'b1;
        end
        hit_next = hit_reg;
        if (req.rd_en) begin
            hit_next = valid_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    prsld_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (req.wr_en),
        .re    (req.rd_en),
        .addr  (addr),
        .wdata (req.color),
        .rdata (ram_q)
    );

    assign rd_color = hit_reg ? ram_q : '0;

endmodule

>>> hdl/prsld_core.sv
// Decoder sequencer: token parsing, run emission and the result register.
module prsld_core import prsld_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH + 2**RUN_W)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  item_t              in_item,
    input  logic [CW-1:0]      w_eff,
    output pal_req_t           pal_req,
    input  logic [COLOR_W-1:0] pal_color,
    output logic               out_valid,
    input  logic               out_ready,
    output result_t            out_res
);

    ctl_state_t           state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic [ALPHA_W-1:0]   alpha_reg, alpha_next;
    logic [CW-1:0]        col_reg, col_next;
    logic                 fin_reg, fin_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_res_reg, out_res_next;
    logic                 lstart_reg, lstart_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [PIXEL_W-1:0]   pix_reg, pix_next;

    // State as seen by the byte under decode, after any line start.
    phase_t               ph_eff;
    logic [RUN_W-1:0]     run_eff;
    logic [ALPHA_W-1:0]   alpha_eff;
    logic [CW-1:0]        col_eff;
    logic                 fin_eff;

    // Outcome of decoding one byte.
    phase_t               dec_ph;
    logic [RUN_W-1:0]     dec_run;
    logic [ALPHA_W-1:0]   dec_alpha;
    logic [CW-1:0]        dec_col;
    logic                 dec_fin;
    logic                 dec_drop;
    logic                 dec_pix;
    logic [PIXEL_W-1:0]   dec_val;
    logic                 dec_emit;

    logic [CW-1:0]        skip_sum;
    logic [CW-1:0]        col_plus_run;
    logic [CW-1:0]        col_plus_one;
    logic [CW-1:0]        emit_inc;
    logic [CW-1:0]        emit_end;
    logic                 out_free;
    logic                 load_out;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        ph_eff    = phase_reg;
        run_eff   = run_reg;
        alpha_eff = alpha_reg;
        col_eff   = col_reg;
        fin_eff   = fin_reg;
        if (lstart_reg) begin
            ph_eff    = PH_TOKEN;
            run_eff   = '0;
            alpha_eff = '0;
            col_eff   = '0;
            fin_eff   = 1'b0;
        end
    end

    assign skip_sum     = col_eff + CW'(byte_reg[RUN_W-1:0]);
    assign col_plus_run = col_eff + CW'(run_eff);
    assign col_plus_one = col_eff + CW'(1);

    always_comb begin
        dec_ph    = ph_eff;
        dec_run   = run_eff;
        dec_alpha = alpha_eff;
        dec_col   = col_eff;
        dec_fin   = fin_eff;
        dec_drop  = 1'b0;
        dec_pix   = 1'b0;
        dec_val   = '0;
        dec_emit  = 1'b0;
        if (!fin_eff) begin
            case (ph_eff)
                PH_TOKEN: begin
                    case (byte_reg[7:6])
                        TK_ALPHA: begin
                            if (byte_reg[5]) begin
                                dec_alpha = byte_reg[ALPHA_W-1:0];
                                dec_run   = RUN_W'(1);
                                dec_ph    = PH_RUN_INDEX;
                            end else if (byte_reg != '0) begin
                                dec_run = {1'b0, byte_reg[ALPHA_W-1:0]};
                                dec_ph  = PH_RUN_ALPHA;
                            end else if (col_eff != '0) begin
                                // End-of-line token; ignored while the column is zero.
                                dec_fin = 1'b1;
                            end
                        end
                        TK_LITERAL: begin
                            dec_run = byte_reg[RUN_W-1:0];
                            if (byte_reg[RUN_W-1:0] != '0) begin
                                dec_ph = PH_LITERAL;
                            end else begin
                                dec_ph  = PH_TOKEN;
                                dec_fin = (col_eff >= w_eff);
                            end
                        end
                        TK_REPEAT: begin
                            dec_run   = byte_reg[RUN_W-1:0];
                            dec_alpha = ALPHA_OPAQUE;
                            dec_ph    = PH_RUN_INDEX;
                        end
                        TK_SKIP: begin
                            dec_col  = skip_sum;
                            dec_drop = (skip_sum > w_eff);
                            dec_ph   = PH_TOKEN;
                            dec_fin  = (skip_sum >= w_eff);
                        end
                        default: begin
                            dec_ph = PH_TOKEN;
                        end
                    endcase
                end
                PH_RUN_ALPHA: begin
                    dec_alpha = byte_reg[ALPHA_W-1:0];
                    dec_ph    = PH_RUN_INDEX;
                end
                PH_RUN_INDEX: begin
                    dec_val = {alpha_eff, pal_color};
                    if (run_eff == '0) begin
                        dec_ph  = PH_TOKEN;
                        dec_fin = (col_eff >= w_eff);
                    end else if (col_eff < w_eff) begin
                        dec_emit = 1'b1;
                    end else begin
                        // Whole run lies past the line end.
                        dec_col  = col_plus_run;
                        dec_run  = '0;
                        dec_drop = 1'b1;
                        dec_ph   = PH_TOKEN;
                        dec_fin  = (col_plus_run >= w_eff);
                    end
                end
                PH_LITERAL: begin
                    dec_val = {ALPHA_OPAQUE, pal_color};
                    if (col_eff < w_eff) begin
                        dec_pix = 1'b1;
                    end else begin
                        dec_drop = 1'b1;
                    end
                    dec_col = col_plus_one;
                    dec_run = run_eff - RUN_W'(1);
                    if (dec_run == '0) begin
                        dec_ph  = PH_TOKEN;
                        dec_fin = (col_plus_one >= w_eff);
                    end
                end
                default: begin
                    dec_ph = PH_TOKEN;
                end
            endcase
        end
    end

    assign emit_inc = col_reg + CW'(1);
    assign emit_end = col_reg + CW'(run_reg);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        run_next     = run_reg;
        alpha_next   = alpha_reg;
        col_next     = col_reg;
        fin_next     = fin_reg;
        lstart_next  = lstart_reg;
        byte_next    = byte_reg;
        pix_next     = pix_reg;
        out_res_next = out_res_reg;
        load_out     = 1'b0;
        pal_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (!in_item.action) begin
                        pal_req.wr_en = 1'b1;
                        pal_req.index = in_item.palette_index;
                        pal_req.color = in_item.palette_color;
                    end else begin
                        pal_req.rd_en = 1'b1;
                        pal_req.index = in_item.data_byte;
                        lstart_next   = in_item.line_start;
                        byte_next     = in_item.data_byte;
                        state_next    = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                if (dec_emit || out_free) begin
                    phase_next  = dec_ph;
                    run_next    = dec_run;
                    alpha_next  = dec_alpha;
                    col_next    = dec_col;
                    fin_next    = dec_fin;
                    lstart_next = 1'b0;
                    if (dec_emit) begin
                        pix_next   = dec_val;
                        state_next = ST_EMIT;
                    end else begin
                        load_out                 = 1'b1;
                        out_res_next.pixel_valid = dec_pix;
                        out_res_next.column      = dec_pix ? COLUMN_W'(col_eff) : '0;
                        out_res_next.pixel_value = dec_pix ? dec_val : '0;
                        out_res_next.line_done   = dec_fin;
                        out_res_next.overrun     = dec_drop;
                        out_res_next.last        = 1'b1;
                        state_next               = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out                 = 1'b1;
                    out_res_next.pixel_valid = 1'b1;
                    out_res_next.column      = COLUMN_W'(col_reg);
                    out_res_next.pixel_value = pix_reg;
                    out_res_next.line_done   = 1'b0;
                    out_res_next.overrun     = 1'b0;
                    out_res_next.last        = 1'b0;
                    if (run_reg == RUN_W'(1) || emit_inc >= w_eff) begin
                        // Last visible pixel: skip the rest of the run in one step.
                        out_res_next.last      = 1'b1;
                        out_res_next.overrun   = (run_reg != RUN_W'(1));
                        out_res_next.line_done = (emit_end >= w_eff);
                        col_next               = emit_end;
                        run_next               = '0;
                        phase_next             = PH_TOKEN;
                        fin_next               = (emit_end >= w_eff);
                        state_next             = ST_IDLE;
                    end else begin
                        col_next = emit_inc;
                        run_next = run_reg - RUN_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_TOKEN;
            run_reg       <= '0;
            alpha_reg     <= '0;
            col_reg       <= '0;
            fin_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            alpha_reg     <= alpha_next;
            col_reg       <= col_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lstart_reg  <= lstart_next;
        byte_reg    <= byte_next;
        pix_reg     <= pix_next;
        out_res_reg <= out_res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the palette run-length sprite line decoder.
`timescale 1ns / 100ps

module tb;
    import prsld_pkg::*;

    // A directed stimulus row. When typed is set, the single result of the row is
    // written out by hand. Otherwise the row is checked against the line decoder
    // model below.
    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } probe_t;

    // The frame width is changed in front of this directed row. The rows before it
    // run at the width that reset leaves.
    localparam int WIDTH_ROW = 2;
    // A palette write is taken while the decoder is idle, so SETTLE_CYCLES idle cycles before
    // a register write let it retire.
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_SHOWN = 10;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [FRAME_WIDTH_W-1:0] cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_action = 1'b0;
    logic                     s_line_start = 1'b0;
    logic [BYTE_W-1:0]        s_data_byte = '0;
    logic [INDEX_W-1:0]       s_palette_index = '0;
    logic [COLOR_W-1:0]       s_palette_color = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_pixel_valid;
    logic [COLUMN_W-1:0]      m_column;
    logic [PIXEL_W-1:0]       m_pixel_value;
    logic                     m_line_done;
    logic                     m_overrun;
    logic                     m_last;

    // This is the testbench's own copy of the decoder state.
    logic [COLOR_W-1:0]       palette_copy [PALETTE_ENTRIES_DEF];
    phase_t                   dec_phase;
    logic [RUN_W-1:0]         run_left;
    logic [ALPHA_W-1:0]       run_alpha;
    int                       line_col;
    bit                       line_over;
    logic [FRAME_WIDTH_W-1:0] width_reg;

    result_t step_results [$];  // results of the byte just decoded
    result_t due_results [$];   // results that the block still owes, oldest first
    probe_t  probes [$];

    int tx_idle_pct = 35;
    int rx_idle_pct = 46;
    int items_sent = 0;
    int live_items = 0;         // stream bytes that were not ignored
    int results_seen = 0;
    int pixels_seen = 0;
    int line_ends_seen = 0;
    int overruns_seen = 0;
    int mismatches = 0;

    palette_rle_sprite_line_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_line_start    (s_line_start),
        .s_data_byte     (s_data_byte),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_valid   (m_pixel_valid),
        .m_column        (m_column),
        .m_pixel_value   (m_pixel_value),
        .m_line_done     (m_line_done),
        .m_overrun       (m_overrun),
        .m_last          (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // A token or a run has been finished. The line ends once the column has reached
    // the width.
    function automatic void close_token(int w);
        dec_phase = PH_TOKEN;
        if (line_col >= w) line_over = 1'b1;
    endfunction

    function automatic void emit_pixel(logic [PIXEL_W-1:0] value);
        result_t r;
        r = '0;
        r.pixel_valid = 1'b1;
        r.column = line_col[COLUMN_W-1:0];
        r.pixel_value = value;
        step_results.push_back(r);
    endfunction

    // Decode one accepted item into step_results. The flag is raised for a stream
    // byte that arrives after the line has ended and carries no line_start.
    task automatic decode_byte(input item_t it, output bit ignored);
        result_t          r;
        bit               dropped;
        int               w;
        logic [BYTE_W-1:0] b;
        logic [PIXEL_W-1:0] value;
        step_results.delete();
        ignored = 1'b0;
        dropped = 1'b0;
        b = it.data_byte;
        if (it.action == 1'b0) begin
            palette_copy[it.palette_index] = it.palette_color;
            return;
        end
        // A frame width of zero acts as one. A 12-bit register cannot exceed MAX_WIDTH.
        w = (width_reg == '0) ? 1 : int'(width_reg);
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (it.line_start) begin
            line_col = 0;
            dec_phase = PH_TOKEN;
            run_left = '0;
            run_alpha = '0;
            line_over = 1'b0;
        end
        if (line_over) begin
            ignored = 1'b1;
        end else begin
            case (dec_phase)
                PH_TOKEN: begin
                    case (b[7:6])
                        TK_ALPHA: begin
                            if (b[5]) begin
                                // This is a single pixel with its own alpha. Its index follows.
                                run_alpha = b[4:0];
                                run_left = RUN_W'(1);
                                dec_phase = PH_RUN_INDEX;
                            end else if (b != '0) begin
                                run_left = {1'b0, b[4:0]};
                                dec_phase = PH_RUN_ALPHA;
                            end else if (line_col != 0) begin
                                // A zero token ends the line, but not at column zero.
                                line_over = 1'b1;
                            end
                        end
                        TK_LITERAL: begin
                            run_left = b[5:0];
                            if (run_left != '0) dec_phase = PH_LITERAL;
                            else close_token(w);
                        end
                        TK_REPEAT: begin
                            run_left = b[5:0];
                            run_alpha = ALPHA_OPAQUE;
                            dec_phase = PH_RUN_INDEX;
                        end
                        default: begin
                            line_col += int'(b[5:0]);
                            if (line_col > w) dropped = 1'b1;
                            close_token(w);
                        end
                    endcase
                end
                PH_RUN_ALPHA: begin
                    run_alpha = b[4:0];
                    dec_phase = PH_RUN_INDEX;
                end
                PH_RUN_INDEX: begin
                    // The whole run comes out of this one index byte. A count of zero
                    // emits nothing.
                    value = {run_alpha, palette_copy[b]};
                    repeat (int'(run_left)) begin
                        if (line_col < w) emit_pixel(value);
                        else dropped = 1'b1;
                        line_col++;
                    end
                    run_left = '0;
                    close_token(w);
                end
                default: begin
                    // This is a literal run. Bytes past the width are still consumed.
                    value = {ALPHA_OPAQUE, palette_copy[b]};
                    if (line_col < w) emit_pixel(value);
                    else dropped = 1'b1;
                    line_col++;
                    run_left = run_left - 1'b1;
                    if (run_left == '0) close_token(w);
                end
            endcase
        end
        if (step_results.size() == 0) step_results.push_back(result_t'('0));
        r = step_results.pop_back();
        r.line_done = line_over;
        r.overrun = dropped;
        r.last = 1'b1;
        step_results.push_back(r);
    endtask

    // Present one item, hold it until it is taken, then record what it should cause.
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        bit ignored;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= it.action;
        s_line_start <= it.line_start;
        s_data_byte <= it.data_byte;
        s_palette_index <= it.palette_index;
        s_palette_color <= it.palette_color;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(it, ignored);
        items_sent++;
        if (it.action && !ignored) live_items++;
        if (typed) due_results.push_back(want);
        else foreach (step_results[k]) due_results.push_back(step_results[k]);
    endtask

    // The fields that a stream byte does not use are random, so their bits toggle too.
    function automatic item_t stream_byte(bit ls, logic [BYTE_W-1:0] b);
        item_t it;
        it.action = 1'b1;
        it.line_start = ls;
        it.data_byte = b;
        it.palette_index = INDEX_W'($urandom_range(255));
        it.palette_color = COLOR_W'($urandom_range(65535));
        return it;
    endfunction

    function automatic item_t palette_write(bit ls, logic [INDEX_W-1:0] idx,
                                            logic [COLOR_W-1:0] color);
        item_t it;
        it.action = 1'b0;
        it.line_start = ls;
        it.data_byte = BYTE_W'($urandom_range(255));
        it.palette_index = idx;
        it.palette_color = color;
        return it;
    endfunction

    // This is a result with no pixel, only flags. It is the last one of its item.
    function automatic result_t flags_only(bit ld, bit ov);
        result_t r;
        r = '0;
        r.line_done = ld;
        r.overrun = ov;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_probe(item_t it, bit typed, result_t want);
        probe_t p;
        p.it = it;
        p.typed = typed;
        p.want = want;
        probes.push_back(p);
    endfunction

    task automatic send_stream(bit ls, logic [BYTE_W-1:0] b);
        send_item(stream_byte(ls, b), 1'b0, result_t'('0));
    endtask

    // Wait for the block to go quiet, then write the frame width.
    task automatic set_width(logic [FRAME_WIDTH_W-1:0] value);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_wdata <= FRAME_WIDTH_W'($urandom_range(4095));
        width_reg = value;
    endtask

    // Run lengths are mostly short, with an occasional long one up to the maximum.
    function automatic logic [5:0] pick_count();
        return 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(6));
    endfunction

    // One well-formed token together with the bytes that it consumes, all with random
    // content.
    task automatic send_token(bit ls);
        int n;
        case ($urandom_range(3))
            0: begin
                if ($urandom_range(1)) begin
                    send_stream(ls, {3'b001, 5'($urandom_range(31))});
                end else begin
                    send_stream(ls, {3'b000, 5'($urandom_range(1, 31))});
                    send_stream(1'b0, BYTE_W'($urandom_range(255)));
                end
                send_stream(1'b0, BYTE_W'($urandom_range(255)));
            end
            1: begin
                n = int'(pick_count());
                send_stream(ls, {2'b01, 6'(n)});
                repeat (n) send_stream(1'b0, BYTE_W'($urandom_range(255)));
            end
            2: begin
                send_stream(ls, {2'b10, pick_count()});
                send_stream(1'b0, BYTE_W'($urandom_range(255)));
            end
            default: send_stream(ls, {2'b11, pick_count()});
        endcase
    endtask

    // Random lines until about quota more items have been sent. Palette writes and
    // stray bytes, some carrying line_start, are mixed in between the tokens.
    task automatic random_lines(int quota);
        int goal;
        int sel;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            send_token(1'b1);
            repeat ($urandom_range(1, 10)) begin
                if (items_sent < goal) begin
                    sel = $urandom_range(99);
                    if (sel < 8) begin
                        send_item(palette_write(1'($urandom_range(1)),
                                                INDEX_W'($urandom_range(255)),
                                                COLOR_W'($urandom_range(65535))),
                                  1'b0, result_t'('0));
                    end else if (sel < 14) begin
                        send_stream($urandom_range(9) == 0, BYTE_W'($urandom_range(255)));
                    end else begin
                        send_token(1'b0);
                    end
                end
            end
            if (items_sent < goal && $urandom_range(1)) send_stream(1'b0, 8'h00);
        end
    endtask

    // The receiver stalls at random. Every accepted result is checked against the
    // oldest expectation.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.pixel_valid = m_pixel_valid;
            got.column = m_column;
            got.pixel_value = m_pixel_value;
            got.line_done = m_line_done;
            got.overrun = m_overrun;
            got.last = m_last;
            results_seen++;
            if (m_pixel_valid) pixels_seen++;
            if (m_line_done) line_ends_seen++;
            if (m_overrun) overruns_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: unexpected result pv=%0b col=%0d px=%06h ld=%0b ov=%0b last=%0b",
                             $realtime, got.pixel_valid, got.column, got.pixel_value,
                             got.line_done, got.overrun, got.last);
            end else begin
                want = due_results.pop_front();
                if (got.pixel_valid !== want.pixel_valid || got.column !== want.column ||
                    got.pixel_value !== want.pixel_value || got.line_done !== want.line_done ||
                    got.overrun !== want.overrun || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"%0t: mismatch expected pv=%0b col=%0d px=%06h ld=%0b ov=%0b",
                                  " last=%0b, got pv=%0b col=%0d px=%06h ld=%0b ov=%0b last=%0b"},
                                 $realtime, want.pixel_valid, want.column, want.pixel_value,
                                 want.line_done, want.overrun, want.last, got.pixel_valid,
                                 got.column, got.pixel_value, got.line_done, got.overrun,
                                 got.last);
                end
            end
        end
        m_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        foreach (palette_copy[k]) palette_copy[k] = '0;
        dec_phase = PH_TOKEN;
        run_left = '0;
        run_alpha = '0;
        line_col = 0;
        line_over = 1'b1;
        width_reg = FRAME_WIDTH_RESET;

        // These rows run at the reset width of one.
        // Bytes are ignored until the first line_start.
        add_probe(stream_byte(1'b0, 8'hA5), 1'b1, flags_only(1'b1, 1'b0));
        // A skip of one fills a line of width one exactly. This is no overrun.
        add_probe(stream_byte(1'b1, 8'hC1), 1'b1, flags_only(1'b1, 1'b0));
        // From here on the width is six. Palette writes ignore line_start.
        add_probe(palette_write(1'b0, 8'h00, 16'hFFFF), 1'b0, result_t'('0));
        add_probe(palette_write(1'b1, 8'hFF, 16'h8421), 1'b0, result_t'('0));
        // A zero token at column zero does nothing.
        add_probe(stream_byte(1'b1, 8'h00), 1'b1, flags_only(1'b0, 1'b0));
        // This is a literal run of two.
        add_probe(stream_byte(1'b0, 8'h42), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'hFF), 1'b0, result_t'('0));
        add_probe(stream_byte(1'b0, 8'h00), 1'b0, result_t'('0));
        // This is a single pixel with alpha 5.
        add_probe(stream_byte(1'b0, 8'h25), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'h00), 1'b0, result_t'('0));
        // This is an alpha run of three at alpha zero. It fills the line to its end.
        add_probe(stream_byte(1'b0, 8'h03), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'hE0), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'hFF), 1'b0, result_t'('0));
        // This is an opaque repeat of four. A skip then runs past the width.
        add_probe(stream_byte(1'b1, 8'h84), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'hFF), 1'b0, result_t'('0));
        add_probe(stream_byte(1'b0, 8'hC5), 1'b1, flags_only(1'b1, 1'b1));
        // The longest repeat gets cut at the width.
        add_probe(stream_byte(1'b1, 8'hBF), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'h00), 1'b0, result_t'('0));
        // The longest skip possible in one byte, and one to exactly the width.
        add_probe(stream_byte(1'b1, 8'hFF), 1'b1, flags_only(1'b1, 1'b1));
        add_probe(stream_byte(1'b1, 8'hC6), 1'b1, flags_only(1'b1, 1'b0));
        // A repeat of zero consumes its index byte and emits nothing.
        add_probe(stream_byte(1'b1, 8'h80), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'h55), 1'b1, flags_only(1'b0, 1'b0));
        // A zero token past column zero ends the line.
        add_probe(stream_byte(1'b0, 8'hC2), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'h00), 1'b1, flags_only(1'b1, 1'b0));
        // A literal run crosses the width. Its late bytes are consumed and dropped.
        add_probe(stream_byte(1'b1, 8'hC5), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'h43), 1'b1, flags_only(1'b0, 1'b0));
        add_probe(stream_byte(1'b0, 8'h12), 1'b0, result_t'('0));
        add_probe(stream_byte(1'b0, 8'hFF), 1'b1, flags_only(1'b0, 1'b1));
        add_probe(stream_byte(1'b0, 8'h00), 1'b1, flags_only(1'b1, 1'b1));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first idle pattern has the sender idle 35% and the receiver 46%.
        foreach (probes[k]) begin
            if (k == WIDTH_ROW) set_width(12'd6);
            send_item(probes[k].it, probes[k].typed, probes[k].want);
        end
        set_width(12'd4095);
        random_lines(55);
        set_width(12'd0);
        random_lines(35);

        // The second idle pattern swaps the two rates.
        tx_idle_pct = 46;
        rx_idle_pct = 35;
        set_width(12'($urandom_range(2, 64)));
        random_lines(110);
        set_width(12'($urandom_range(65, 300)));
        random_lines(55);

        // In the last stretch neither side idles.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_width(12'd16);
        random_lines(85);

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("Sent %0d items (%0d stream bytes decoded) at widths 1, 6, 4095, 0, 16 and two random.",
                 items_sent, live_items);
        $display("Checked %0d results: %0d pixels, %0d line ends, %0d overruns, %0d mismatches.",
                 results_seen, pixels_seen, line_ends_seen, overruns_seen, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // This is a watchdog, set well beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d results still expected.", due_results.size());
        $display("tb: failure");
        $finish;
    end

endmodule
